// ----- hw/rtl/fsml_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants for the flash sector map lookup.
package fsml_pkg;

   localparam int unsigned DEFAULT_TABLE_DEPTH = 16;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned ENTRIES_W = 5;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned DIV_STEP_W = 5;
   localparam logic [DATA_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
   localparam logic [DIV_STEP_W-1:0] DIV_LAST_STEP = 5'd31;

   // request commands
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_ANSWERED = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_STORED = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_CLOSED = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_CLEARED = 3'd4;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_BASE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_LENGTH = 1'd1;

   typedef struct packed {
      logic [1:0] cmd;
      logic [DATA_W-1:0] entry_size;
      logic [DATA_W-1:0] entry_offset;
      logic [DATA_W-1:0] query_address;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic in_range;
      logic [DATA_W-1:0] sector_length;
      logic [DATA_W-1:0] sector_start;
      logic [ENTRIES_W-1:0] table_entries;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_READ,
      S_COMPARE,
      S_POST,
      S_DIVIDE,
      S_FIXUP,
      S_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic decode;
      logic read;
      logic compare;
      logic post;
      logic div_step;
      logic fixup;
      logic load_rsp;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic walk_go;
      logic walk_stop;
      logic size_zero;
      logic div_last;
   } dp_stat_type;

endpackage

// ----- hw/rtl/fsml_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencing state machine for the flash sector map lookup.
module fsml_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  fsml_pkg::dp_stat_type stat,
   output fsml_pkg::ctl_cmd_type ctl
);

   fsml_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fsml_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      ctl = '0;
      req_ready = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         fsml_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in = fsml_pkg::S_DECODE;
            end
         end
         fsml_pkg::S_DECODE: begin
            ctl.decode = 1'b1;
            state_in = stat.walk_go ? fsml_pkg::S_READ : fsml_pkg::S_FINISH;
         end
         fsml_pkg::S_READ: begin
            ctl.read = 1'b1;
            state_in = fsml_pkg::S_COMPARE;
         end
         fsml_pkg::S_COMPARE: begin
            ctl.compare = 1'b1;
            state_in = stat.walk_stop ? fsml_pkg::S_POST : fsml_pkg::S_READ;
         end
         fsml_pkg::S_POST: begin
            ctl.post = 1'b1;
            state_in = stat.size_zero ? fsml_pkg::S_FINISH : fsml_pkg::S_DIVIDE;
         end
         fsml_pkg::S_DIVIDE: begin
            ctl.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = fsml_pkg::S_FIXUP;
            end
         end
         fsml_pkg::S_FIXUP: begin
            ctl.fixup = 1'b1;
            state_in = fsml_pkg::S_FINISH;
         end
         fsml_pkg::S_FINISH: begin
            if (rsp_free) begin
               ctl.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = fsml_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = fsml_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ----- hw/rtl/fsml_dp.sv -----
`timescale 1ns / 1ps
// Datapath: descriptor table, window test, table walk and remainder divider.
module fsml_dp #(
   parameter int unsigned TABLE_DEPTH = fsml_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_wr_en,
   input  logic [fsml_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fsml_pkg::DATA_W-1:0] csr_wdata,
   input  fsml_pkg::req_type req_data,
   output fsml_pkg::rsp_type rsp_data,
   input  fsml_pkg::ctl_cmd_type ctl,
   output fsml_pkg::dp_stat_type stat
);

   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned W = fsml_pkg::DATA_W;

   logic [W-1:0] size_mem [TABLE_DEPTH];
   logic [W-1:0] off_mem [TABLE_DEPTH];

   logic [W-1:0] base_ff, length_ff;
   fsml_pkg::req_type req_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic closed_ff, closed_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [W-1:0] off_ff, off_in;
   logic [W-1:0] grp_ff, grp_in;
   logic [W-1:0] size_ff, size_in;
   logic [W-1:0] rd_size_ff, rd_off_ff;
   logic [W-1:0] rem_ff, rem_in;
   logic [W-1:0] div_ff, div_in;
   logic [fsml_pkg::DIV_STEP_W-1:0] step_ff, step_in;
   logic [fsml_pkg::STATUS_W-1:0] status_ff, status_in;
   logic in_range_ff, in_range_in;
   logic [W-1:0] len_ff, len_in;
   logic [W-1:0] start_ff, start_in;
   fsml_pkg::rsp_type rsp_ff;

   logic [W-1:0] window_end;
   logic in_window;
   logic terminator;
   logic table_full;
   logic mem_we;
   logic walk_last;
   logic [W:0] rem_shift;
   logic rem_ge;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         length_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            fsml_pkg::CSR_DEVICE_BASE: base_ff <= csr_wdata;
            fsml_pkg::CSR_DEVICE_LENGTH: length_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // descriptor table; one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         size_mem[count_ff[IDX_W-1:0]] <= req_ff.entry_size;
         off_mem[count_ff[IDX_W-1:0]] <= req_ff.entry_offset;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.read) begin
         rd_size_ff <= size_mem[idx_ff];
         rd_off_ff <= off_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         closed_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         closed_ff <= closed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         req_ff <= req_data;
      end
      if (ctl.load_rsp) begin
         rsp_ff <= '{status: status_ff, in_range: in_range_ff, sector_length: len_ff,
                     sector_start: start_ff,
                     table_entries: fsml_pkg::ENTRIES_W'(count_ff)};
      end
      idx_ff <= idx_in;
      off_ff <= off_in;
      grp_ff <= grp_in;
      size_ff <= size_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      step_ff <= step_in;
      status_ff <= status_in;
      in_range_ff <= in_range_in;
      len_ff <= len_in;
      start_ff <= start_in;
   end

   assign window_end = base_ff + length_ff;
   assign in_window = (req_ff.query_address >= base_ff) &&
                      (req_ff.query_address < window_end);
   assign terminator = (req_ff.entry_size == '0) ||
                       ((req_ff.entry_size == fsml_pkg::ALL_ONES) &&
                        (req_ff.entry_offset == fsml_pkg::ALL_ONES));
   assign table_full = (count_ff >= CNT_W'(TABLE_DEPTH));
   assign mem_we = ctl.decode && (req_ff.cmd == fsml_pkg::CMD_APPEND) &&
                   !closed_ff && !table_full && !terminator;
   assign walk_last = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign rem_shift = {rem_ff, div_ff[W-1]};
   assign rem_ge = (rem_shift >= {1'b0, size_ff});

   assign stat.walk_go = (req_ff.cmd == fsml_pkg::CMD_QUERY) && in_window && (count_ff != '0);
   assign stat.walk_stop = (off_ff < rd_off_ff) || walk_last;
   assign stat.size_zero = (size_ff == '0);
   assign stat.div_last = (step_ff == fsml_pkg::DIV_LAST_STEP);

   always_comb begin
      count_in = count_ff;
      closed_in = closed_ff;
      idx_in = idx_ff;
      off_in = off_ff;
      grp_in = grp_ff;
      size_in = size_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      step_in = step_ff;
      status_in = status_ff;
      in_range_in = in_range_ff;
      len_in = len_ff;
      start_in = start_ff;

      if (ctl.decode) begin
         in_range_in = 1'b0;
         len_in = '0;
         start_in = '0;
         idx_in = '0;
         grp_in = '0;
         size_in = '0;
         off_in = req_ff.query_address - base_ff;
         case (req_ff.cmd)
            fsml_pkg::CMD_CLEAR: begin
               count_in = '0;
               closed_in = 1'b0;
               status_in = fsml_pkg::STATUS_CLEARED;
            end
            fsml_pkg::CMD_APPEND: begin
               if (closed_ff || table_full) begin
                  status_in = fsml_pkg::STATUS_DROPPED;
               end else if (terminator) begin
                  closed_in = 1'b1;
                  status_in = fsml_pkg::STATUS_CLOSED;
               end else begin
                  count_in = count_ff + CNT_W'(1);
                  status_in = fsml_pkg::STATUS_STORED;
               end
            end
            fsml_pkg::CMD_QUERY: begin
               in_range_in = in_window;
               status_in = fsml_pkg::STATUS_ANSWERED;
            end
            default: begin
               status_in = fsml_pkg::STATUS_DROPPED;
            end
         endcase
      end

      // keep the last descriptor whose group offset is not above the offset
      if (ctl.compare && !(off_ff < rd_off_ff)) begin
         grp_in = rd_off_ff;
         size_in = rd_size_ff;
         idx_in = idx_ff + IDX_W'(1);
      end

      if (ctl.post) begin
         len_in = size_ff;
         if (size_ff == '0) begin
            start_in = req_ff.query_address;
         end
         div_in = off_ff - grp_ff;
         rem_in = '0;
         step_in = '0;
      end

      // restoring division; only the remainder is kept
      if (ctl.div_step) begin
         rem_in = rem_ge ? W'(rem_shift - {1'b0, size_ff}) : rem_shift[W-1:0];
         div_in = {div_ff[W-2:0], 1'b0};
         step_in = step_ff + fsml_pkg::DIV_STEP_W'(1);
      end

      // base + grp + floor((off - grp) / size) * size == address - remainder
      if (ctl.fixup) begin
         start_in = req_ff.query_address - rem_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- hw/rtl/flash_sector_map_lookup.sv -----
`timescale 1ns / 1ps
// Top level of the flash sector map lookup: controller plus datapath.
//
// Clear, append and no-op requests go from acceptance through decode to a
// response in the output register. A query outside the device window or on an
// empty table does the same; otherwise it walks the descriptor table, one
// registered table read and one compare per entry, until the first descriptor
// above the address or the end of the table. An address below the first
// descriptor then finishes without dividing; any other runs a one-bit-per-cycle
// 32-step remainder divider and a fixup step. One request is worked on at a
// time; the next is taken once the previous response sits in the output
// register.
module flash_sector_map_lookup #(
   parameter int unsigned TABLE_DEPTH = fsml_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  fsml_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output fsml_pkg::rsp_type rsp_data,
   input  logic csr_wr_en,
   input  logic [fsml_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fsml_pkg::DATA_W-1:0] csr_wdata
);

   fsml_pkg::ctl_cmd_type ctl;
   fsml_pkg::dp_stat_type stat;

   fsml_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .stat(stat),
      .ctl(ctl)
   );

   fsml_dp #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_data(req_data),
      .rsp_data(rsp_data),
      .ctl(ctl),
      .stat(stat)
   );

endmodule

// ----- test/fsml_checker.sv -----
`timescale 1ns / 1ps
// Response checker for the flash sector map lookup: tracks the table and predicts every response.
module fsml_checker #(
   parameter int unsigned TABLE_DEPTH = fsml_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  fsml_pkg::req_type req_data,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  fsml_pkg::rsp_type rsp_data,
   input  logic csr_wr_en,
   input  logic [fsml_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fsml_pkg::DATA_W-1:0] csr_wdata,
   output int fail_count,
   output int results_due
);
   import fsml_pkg::*;

   logic [DATA_W-1:0] flash_base;
   logic [DATA_W-1:0] flash_length;
   logic [DATA_W-1:0] sector_size_tbl [TABLE_DEPTH];
   logic [DATA_W-1:0] group_offset_tbl [TABLE_DEPTH];
   logic [ENTRIES_W-1:0] entry_count;
   logic table_sealed;
   rsp_type expected_q[$];

   initial begin
      fail_count = 0;
      results_due = 0;
   end

   function automatic rsp_type predict_response(req_type r);
      rsp_type res;
      logic [DATA_W-1:0] window_end;
      logic [DATA_W-1:0] offset;
      logic [DATA_W-1:0] group;
      logic [DATA_W-1:0] size;
      int i;
      res = '0;
      case (r.cmd)
         CMD_CLEAR: begin
            entry_count = '0;
            table_sealed = 1'b0;
            res.status = STATUS_CLEARED;
         end
         CMD_APPEND: begin
            if (table_sealed || entry_count >= TABLE_DEPTH) begin
               res.status = STATUS_DROPPED;
            end else if (r.entry_size == '0 ||
                         (r.entry_size == ALL_ONES && r.entry_offset == ALL_ONES)) begin
               table_sealed = 1'b1;
               res.status = STATUS_CLOSED;
            end else begin
               sector_size_tbl[entry_count] = r.entry_size;
               group_offset_tbl[entry_count] = r.entry_offset;
               entry_count = entry_count + 1'b1;
               res.status = STATUS_STORED;
            end
         end
         CMD_QUERY: begin
            res.status = STATUS_ANSWERED;
            window_end = flash_base + flash_length;
            res.in_range = (r.query_address >= flash_base) && (r.query_address < window_end);
            if (res.in_range && entry_count != '0) begin
               offset = r.query_address - flash_base;
               group = '0;
               size = '0;
               // last descriptor whose offset is not above the address wins
               for (i = 0; i < entry_count; i++) begin
                  if (offset < group_offset_tbl[i])
                     break;
                  group = group_offset_tbl[i];
                  size = sector_size_tbl[i];
               end
               res.sector_length = size;
               if (size == '0)
                  res.sector_start = r.query_address;
               else
                  res.sector_start = flash_base + group + ((offset - group) / size) * size;
            end
         end
         default: res.status = STATUS_DROPPED;
      endcase
      res.table_entries = entry_count;
      return res;
   endfunction

   function automatic void check_field(string field, logic [DATA_W-1:0] want,
                                       logic [DATA_W-1:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         flash_base = '0;
         flash_length = '0;
         entry_count = '0;
         table_sealed = 1'b0;
         expected_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               fail_count++;
               $display("%0t: response with no request outstanding: expected none, got 0x%0h",
                        $time, rsp_data);
            end else begin
               want = expected_q.pop_front();
               check_field("status", DATA_W'(want.status), DATA_W'(rsp_data.status));
               check_field("in_range", DATA_W'(want.in_range), DATA_W'(rsp_data.in_range));
               check_field("sector_length", want.sector_length, rsp_data.sector_length);
               check_field("sector_start", want.sector_start, rsp_data.sector_start);
               check_field("table_entries", DATA_W'(want.table_entries),
                           DATA_W'(rsp_data.table_entries));
            end
         end
         if (req_valid && req_ready)
            expected_q.push_back(predict_response(req_data));
         if (csr_wr_en) begin
            if (csr_index == CSR_DEVICE_BASE)
               flash_base = csr_wdata;
            else if (csr_index == CSR_DEVICE_LENGTH)
               flash_length = csr_wdata;
         end
      end
      results_due = expected_q.size();
   end

endmodule

// ----- test/flash_sector_map_lookup_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the flash sector map lookup: clock, reset, stimulus and verdict.
module flash_sector_map_lookup_tb;
   import fsml_pkg::*;

   localparam int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
   localparam logic [1:0] CMD_NOP = 2'd3;
   localparam logic [DATA_W-1:0] DIRECTED_BASE = 32'h0800_0000;
   localparam logic [DATA_W-1:0] DIRECTED_LEN = 32'h0010_0000;
   localparam int PHASES = 9;
   localparam int ITEMS_PER_PHASE = 88;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 80;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_DEVICE_BASE;
   logic [DATA_W-1:0] csr_wdata = '0;

   int fail_count;
   int results_due;
   int items_sent = 0;
   bit steady = 1'b0;
   logic [DATA_W-1:0] window_base = '0;
   logic [DATA_W-1:0] window_len = '0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   flash_sector_map_lookup #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   fsml_checker #(.TABLE_DEPTH(TABLE_DEPTH)) scoreboard (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .fail_count(fail_count),
      .results_due(results_due)
   );

   function automatic req_type make_request(logic [1:0] cmd, logic [DATA_W-1:0] size,
                                            logic [DATA_W-1:0] offset,
                                            logic [DATA_W-1:0] addr);
      req_type r;
      r.cmd = cmd;
      r.entry_size = size;
      r.entry_offset = offset;
      r.query_address = addr;
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] pick_size();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 7)
         return 32'd1 << $urandom_range(0, 16);
      else if (sel < 9)
         return $urandom_range(1, 32'h0001_0000);
      return $urandom;
   endfunction

   // mostly inside the device window, some at its edges, some anywhere
   function automatic logic [DATA_W-1:0] window_address();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 7 && window_len != '0)
         return window_base + ($urandom % window_len);
      else if (sel == 7)
         return window_base + window_len - $urandom_range(0, 1);
      else if (sel == 8)
         return window_base - $urandom_range(0, 1);
      return $urandom;
   endfunction

   // entered and left at a falling edge; valid stays up for a back-to-back request
   task automatic issue(input req_type item);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (results_due != 0) @(negedge clock);
   endtask

   task automatic write_config(input logic [DATA_W-1:0] base, input logic [DATA_W-1:0] len);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_DEVICE_BASE;
      csr_wdata <= base;
      @(negedge clock);
      csr_index <= CSR_DEVICE_LENGTH;
      csr_wdata <= len;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      window_base = base;
      window_len = len;
   endtask

   initial begin : response_side
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 15);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      logic [DATA_W-1:0] base_set [6];
      logic [DATA_W-1:0] len_set [6];
      logic [DATA_W-1:0] offset;
      logic [DATA_W-1:0] step;
      int phase;
      int phase_end;
      int count;
      int j;
      int sel;
      base_set = '{32'h0800_0000, 32'h0, 32'h0, ALL_ONES, 32'h8000_0000, 32'hFFFF_0000};
      len_set = '{32'h0010_0000, 32'h0, ALL_ONES, ALL_ONES, 32'h9000_0000, 32'h0001_0000};

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      write_config(DIRECTED_BASE, DIRECTED_LEN);

      // directed: empty table, window edges, closing, dropping, clearing
      issue(make_request(CMD_QUERY, '0, '0, DIRECTED_BASE + 32'h100));
      issue(make_request(CMD_QUERY, '0, '0, 32'h0));
      issue(make_request(CMD_QUERY, '0, '0, ALL_ONES));
      issue(make_request(CMD_APPEND, 32'h400, 32'h1000, '0));
      issue(make_request(CMD_QUERY, '0, '0, DIRECTED_BASE + 32'h10));
      issue(make_request(CMD_QUERY, '0, '0, DIRECTED_BASE + 32'h1234));
      issue(make_request(CMD_APPEND, 32'h8000, 32'h8000, '0));
      issue(make_request(CMD_APPEND, ALL_ONES, 32'h2_0000, '0));
      issue(make_request(CMD_QUERY, '0, '0, DIRECTED_BASE + DIRECTED_LEN - 1));
      issue(make_request(CMD_QUERY, '0, '0, DIRECTED_BASE + DIRECTED_LEN));
      issue(make_request(CMD_QUERY, '0, '0, DIRECTED_BASE - 1));
      issue(make_request(CMD_APPEND, 32'h0, 32'h4_0000, '0));
      issue(make_request(CMD_APPEND, 32'h100, 32'h5_0000, '0));
      issue(make_request(CMD_NOP, $urandom, $urandom, $urandom));
      issue(make_request(CMD_QUERY, '0, '0, DIRECTED_BASE + 32'h9000));
      issue(make_request(CMD_CLEAR, '0, '0, '0));
      issue(make_request(CMD_APPEND, ALL_ONES, ALL_ONES, '0));
      issue(make_request(CMD_QUERY, '0, '0, DIRECTED_BASE));
      issue(make_request(CMD_CLEAR, ALL_ONES, ALL_ONES, ALL_ONES));
      issue(make_request(CMD_APPEND, 32'h1, ALL_ONES, ALL_ONES));
      issue(make_request(CMD_QUERY, '0, '0, DIRECTED_BASE + 32'h5));
      issue(make_request(CMD_NOP, ALL_ONES, ALL_ONES, ALL_ONES));

      for (phase = 0; phase < PHASES; phase++) begin
         // phase 0 doubles as the full drain before new traffic
         wait_idle();
         if (phase < 6)
            write_config(base_set[phase], len_set[phase]);
         else
            write_config($urandom, $urandom_range(1, 32'h0100_0000));
         phase_end = items_sent + ITEMS_PER_PHASE;
         while (items_sent < phase_end) begin
            steady = ($urandom_range(0, 4) == 0);
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
               // build a table, maybe seal it, then look up addresses in it
               issue(make_request(CMD_CLEAR, $urandom, $urandom, $urandom));
               count = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 18) : $urandom_range(1, 6);
               step = (window_len >> 5) + 1;
               offset = $urandom_range(0, 1) ? '0 : $urandom_range(1, step);
               for (j = 0; j < count; j++) begin
                  issue(make_request(CMD_APPEND, pick_size(), offset, $urandom));
                  offset = offset + $urandom_range(1, step);
               end
               sel = $urandom_range(0, 3);
               if (sel == 0)
                  issue(make_request(CMD_APPEND, '0, $urandom, $urandom));
               else if (sel == 1)
                  issue(make_request(CMD_APPEND, ALL_ONES, ALL_ONES, $urandom));
               if ($urandom_range(0, 3) == 0)
                  issue(make_request(CMD_APPEND, pick_size(), offset, $urandom));
               repeat ($urandom_range(2, 8))
                  issue(make_request(CMD_QUERY, $urandom, $urandom, window_address()));
            end else begin
               repeat ($urandom_range(3, 10))
                  issue(make_request(2'($urandom_range(0, 3)), $urandom, $urandom,
                                     $urandom_range(0, 1) ? window_address() : $urandom));
            end
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/fsml_pkg.sv
hw/rtl/fsml_ctrl.sv
hw/rtl/fsml_dp.sv
hw/rtl/flash_sector_map_lookup.sv
test/fsml_checker.sv
test/flash_sector_map_lookup_tb.sv
